// ----- src/uhr_pkg.sv -----
// ----------------------------------------------------------------------------
// uhr_pkg
// Shared types and constants for the undo/redo history ring.
// ----------------------------------------------------------------------------
package uhr_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int DATA_W    = 32;
    localparam int OP_W      = 2;

    localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
    localparam logic [OP_W-1:0] OP_BACK = 2'd1;
    localparam logic [OP_W-1:0] OP_FWD  = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [DATA_W-1:0] entry_value;
    } t_req;

    typedef struct packed {
        logic              ok;
        logic [DATA_W-1:0] result_value;
    } t_rsp;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load_req;
        logic exec_push;
        logic exec_step;
        logic exec_refuse;
        logic read_done;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_push;
        logic step_ok;
    } t_sts;

endpackage

// ----- src/uhr_ram.sv -----
// ----------------------------------------------------------------------------
// uhr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module uhr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/uhr_ctrl.sv -----
// ----------------------------------------------------------------------------
// uhr_ctrl
// Sequencer: takes a request, has the datapath run it, waits for a read after a step.
// ----------------------------------------------------------------------------
module uhr_ctrl
    import uhr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load_req = 1'b1;
                    n_state        = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_sts.is_push) begin
                    o_cmd.exec_push = 1'b1;
                    n_state         = S_IDLE;
                end else if (i_sts.step_ok) begin
                    o_cmd.exec_step = 1'b1;
                    n_state         = S_READ;
                end else begin
                    o_cmd.exec_refuse = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            S_READ: begin
                o_cmd.read_done = 1'b1;
                n_state         = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy = (r_state != S_IDLE);

endmodule

// ----- src/uhr_dp.sv -----
// ----------------------------------------------------------------------------
// uhr_dp
// Ring indices, entry memory and result registers.
// ----------------------------------------------------------------------------
module uhr_dp
    import uhr_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_req i_req,
    input  t_cmd i_cmd,
    output t_sts o_sts,
    output t_rsp o_rsp,
    output logic o_done
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam logic [IDX_W-1:0] LAST = IDX_W'(DEPTH - 1);

    logic [OP_W-1:0]   r_op;
    logic [DATA_W-1:0] r_val;
    logic [IDX_W-1:0]  r_cur;
    logic [IDX_W-1:0]  r_old;
    logic [IDX_W-1:0]  r_new;
    logic              r_nonempty;
    logic              r_ok;
    logic [DATA_W-1:0] r_res;
    logic              r_done;

    logic [IDX_W-1:0]  cur_next;
    logic [IDX_W-1:0]  cur_prev;
    logic [IDX_W-1:0]  old_next;
    logic [IDX_W-1:0]  target;
    logic [DATA_W-1:0] ram_rdata;

    assign cur_next = (r_cur == LAST) ? '0 : r_cur + 1'b1;
    assign cur_prev = (r_cur == '0) ? LAST : r_cur - 1'b1;
    assign old_next = (r_old == LAST) ? '0 : r_old + 1'b1;
    assign target   = (r_op == OP_BACK) ? cur_prev : cur_next;

    // valid slots always form the run after the oldest slot up to the newest,
    // and the current slot lies inside it
    always_comb begin
        o_sts.is_push = (r_op == OP_PUSH);
        case (r_op)
            OP_BACK: o_sts.step_ok = r_nonempty && (cur_prev != r_old);
            OP_FWD:  o_sts.step_ok = r_nonempty && (r_cur != r_new);
            default: o_sts.step_ok = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_op  <= i_req.operation;
            r_val <= i_req.entry_value;
        end
        if (i_cmd.exec_push) begin
            r_ok  <= 1'b1;
            r_res <= r_val;
        end else if (i_cmd.exec_refuse) begin
            r_ok  <= 1'b0;
            r_res <= '0;
        end else if (i_cmd.read_done) begin
            r_ok  <= 1'b1;
            r_res <= ram_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur      <= '0;
            r_old      <= '0;
            r_new      <= '0;
            r_nonempty <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_done <= i_cmd.exec_push | i_cmd.exec_refuse | i_cmd.read_done;
            if (i_cmd.exec_push) begin
                r_cur      <= cur_next;
                r_new      <= cur_next;
                r_nonempty <= 1'b1;
                // overwrite of the oldest slot pushes the sentinel on
                if (cur_next == r_old) begin
                    r_old <= old_next;
                end
            end else if (i_cmd.exec_step) begin
                r_cur <= target;
            end
        end
    end

    uhr_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.exec_push),
        .i_waddr (cur_next),
        .i_wdata (r_val),
        .i_raddr (target),
        .o_rdata (ram_rdata)
    );

    assign o_rsp.ok           = r_ok;
    assign o_rsp.result_value = r_res;
    assign o_done             = r_done;

endmodule

// ----- src/undo_redo_history_ring_core.sv -----
// ----------------------------------------------------------------------------
// undo_redo_history_ring_core
// Circular undo/redo history: push, step back, step forward.
// ----------------------------------------------------------------------------
// push: the request is registered, S_EXEC writes the ram and registers o_done; a new request is taken only in S_IDLE
// back/forward that succeed: S_EXEC steps the index, S_READ registers the ram read, then o_done
// refused or unused codes: refused in S_EXEC, as push
// results cannot be stalled; o_done is high for one cycle per request
// reset empties the history and clears all three indices; no clearing pass
module undo_redo_history_ring_core
    import uhr_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_req i_req,
    output logic busy,
    output logic o_done,
    output t_rsp o_rsp
);

    t_cmd cmd;
    t_sts sts;

    uhr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    uhr_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_rsp   (o_rsp),
        .o_done  (o_done)
    );

endmodule
